/* hw/rtl/chained_hash_map_engine_top_assert.svh */
// assertion macros shared by the hash map engine modules
`ifndef CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define CHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/chmap_pkg.sv */
// ----------------------------------------------------------------------------
// chmap_pkg
// types and constants of the chained hash map engine
// ----------------------------------------------------------------------------
package chmap_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RESET_CAPACITY  = 1021;

	localparam int CAP_CFG_W = 11;
	localparam int IDX_OUT_W = 10;
	localparam int LIVE_W    = 11;
	localparam int VER_W     = 32;
	localparam int H31_W     = 31;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_ADD    = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} stat_code_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_HEAD_RD,
		S_HEAD_TAKE,
		S_CHECK,
		S_CMP,
		S_ACT,
		S_PUSH,
		S_MISS,
		S_POP,
		S_WRITE,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_DIV,
		CMD_HEAD_RD,
		CMD_HEAD_TAKE,
		CMD_ENT_RD,
		CMD_ADV,
		CMD_HIT,
		CMD_FIN_LOOKUP,
		CMD_FIN_DUP,
		CMD_FIN_MISS,
		CMD_FIN_FULL,
		CMD_REPLACE,
		CMD_UNLINK,
		CMD_PUSH,
		CMD_ALLOC_RD,
		CMD_ALLOC_POP,
		CMD_TAKE_NEW,
		CMD_WRITE
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic div_last;
		logic walk_ok;
		logic match;
		logic free_avail;
		logic used_avail;
		req_t req;
	} dp_stat_t;

endpackage

/* hw/rtl/chained_hash_map_engine_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_map_engine_top
// key/value map with chained buckets and a free list of removed entries
// ----------------------------------------------------------------------------
// usage
//  - a request (req_type, hash_in, key, value_in) transfers on a rising edge
//    with start high and busy low; busy stays high until the result is out
//  - the result shows on status/found/value_out/entry_index/live_count/version
//    for exactly one cycle with done high; the receiver cannot stall it
//  - bucket_capacity is written over cfg_valid/cfg_ready/cfg_data (ready is
//    always high); a write clears the table and keeps the version counter
// steps of a request
//  - an accept step, then bit-serial modulo by the capacity
//  - a read of the bucket head and its take, then for each chain entry visited
//    a registered entry memory read and a compare, and at last the end check
//  - the update steps and a result step; for a short chain the divider and
//    the single entry memory port set the time a request takes
// reset and clear
//  - after reset, and after each capacity write, a clearing pass empties the
//    bucket head memory one entry a cycle, with busy high
// ----------------------------------------------------------------------------
module chained_hash_map_engine_top #(
	parameter int MAX_ENTRIES = chmap_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_WIDTH   = chmap_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = chmap_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [63:0]                     hash_in,
	input  logic [KEY_WIDTH-1:0]            key,
	input  logic [VALUE_WIDTH-1:0]          value_in,
	// result channel
	output logic                            done,
	output logic [1:0]                      status,
	output logic                            found,
	output logic [VALUE_WIDTH-1:0]          value_out,
	output logic [chmap_pkg::IDX_OUT_W-1:0] entry_index,
	output logic [chmap_pkg::LIVE_W-1:0]    live_count,
	output logic [chmap_pkg::VER_W-1:0]     version,
	// capacity register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [chmap_pkg::CAP_CFG_W-1:0] cfg_data
);
	import chmap_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;
	logic     cfg_fire;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	// sequencer: one command to the datapath per cycle
	chmap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg_fire (cfg_fire),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// memories, modulo unit, counters and result registers
	chmap_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_fire    (cfg_fire),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.hash_in     (hash_in),
		.key         (key),
		.value_in    (value_in),
		.stat        (stat),
		.status      (status),
		.found       (found),
		.value_out   (value_out),
		.entry_index (entry_index),
		.live_count  (live_count),
		.version     (version)
	);

endmodule

/* hw/rtl/chmap_ctrl.sv */
// ----------------------------------------------------------------------------
// chmap_ctrl
// request sequencer: clearing, division, chain walk and update steps
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_top_assert.svh"

module chmap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_fire,
	input  chmap_pkg::dp_stat_t stat,
	output chmap_pkg::cmd_t   cmd,
	output logic              busy,
	output logic              done
);
	import chmap_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:     if (stat.clear_last) state_d = S_IDLE;
			S_IDLE:      if (start) state_d = S_DIV;
			S_DIV:       if (stat.div_last) state_d = S_HEAD_RD;
			S_HEAD_RD:   state_d = S_HEAD_TAKE;
			S_HEAD_TAKE: state_d = S_CHECK;
			S_CHECK:     state_d = stat.walk_ok ? S_CMP : S_MISS;
			S_CMP:       state_d = stat.match ? S_ACT : S_CHECK;
			S_ACT:       state_d = (stat.req == REQ_REMOVE) ? S_PUSH : S_DONE;
			S_PUSH:      state_d = S_DONE;
			S_MISS: begin
				if (stat.req == REQ_LOOKUP || stat.req == REQ_REMOVE) state_d = S_DONE;
				else if (stat.free_avail) state_d = S_POP;
				else if (stat.used_avail) state_d = S_WRITE;
				else state_d = S_DONE;
			end
			S_POP:       state_d = S_WRITE;
			S_WRITE:     state_d = S_DONE;
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_CLEAR;
		endcase
		if (cfg_fire) state_d = S_CLEAR;
	end

	// outputs
	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_CLEAR:     cmd = CMD_CLEAR;
			S_IDLE:      if (start) cmd = CMD_LOAD;
			S_DIV:       cmd = CMD_DIV;
			S_HEAD_RD:   cmd = CMD_HEAD_RD;
			S_HEAD_TAKE: cmd = CMD_HEAD_TAKE;
			S_CHECK:     if (stat.walk_ok) cmd = CMD_ENT_RD;
			S_CMP:       cmd = stat.match ? CMD_HIT : CMD_ADV;
			S_ACT: begin
				case (stat.req)
					REQ_LOOKUP: cmd = CMD_FIN_LOOKUP;
					REQ_INSERT: cmd = CMD_REPLACE;
					REQ_ADD:    cmd = CMD_FIN_DUP;
					REQ_REMOVE: cmd = CMD_UNLINK;
					default:    cmd = CMD_NONE;
				endcase
			end
			S_PUSH:      cmd = CMD_PUSH;
			S_MISS: begin
				if (stat.req == REQ_LOOKUP || stat.req == REQ_REMOVE) cmd = CMD_FIN_MISS;
				else if (stat.free_avail) cmd = CMD_ALLOC_RD;
				else if (stat.used_avail) cmd = CMD_TAKE_NEW;
				else cmd = CMD_FIN_FULL;
			end
			S_POP:       cmd = CMD_ALLOC_POP;
			S_WRITE:     cmd = CMD_WRITE;
			default:     cmd = CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`CHM_ASSERT_NXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`CHM_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy && !cfg_fire, busy,
		"accepted request did not make the engine busy")
	`CHM_ASSERT_NXT(a_cfg_clear, clk, arst_n, cfg_fire, state_q == S_CLEAR,
		"capacity write did not start a clearing pass")

endmodule

/* hw/rtl/chmap_dp.sv */
// ----------------------------------------------------------------------------
// chmap_dp
// entry memories, bucket heads, modulo unit and counters of the hash map
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_top_assert.svh"

module chmap_dp #(
	parameter int MAX_ENTRIES = chmap_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_WIDTH   = chmap_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = chmap_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  chmap_pkg::cmd_t                 cmd,
	input  logic                            cfg_fire,
	input  logic [chmap_pkg::CAP_CFG_W-1:0] cfg_data,
	input  logic [1:0]                      req_type,
	input  logic [63:0]                     hash_in,
	input  logic [KEY_WIDTH-1:0]            key,
	input  logic [VALUE_WIDTH-1:0]          value_in,
	output chmap_pkg::dp_stat_t             stat,
	output logic [1:0]                      status,
	output logic                            found,
	output logic [VALUE_WIDTH-1:0]          value_out,
	output logic [chmap_pkg::IDX_OUT_W-1:0] entry_index,
	output logic [chmap_pkg::LIVE_W-1:0]    live_count,
	output logic [chmap_pkg::VER_W-1:0]     version
);
	import chmap_pkg::*;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LINK_W = IDX_W + 1;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_ENTRIES);
	localparam logic [LINK_W-1:0] CAP_RST =
		LINK_W'((RESET_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES : RESET_CAPACITY);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(H31_W - 1);

	// memories
	logic [LINK_W-1:0]      head_mem  [MAX_ENTRIES];
	logic [H31_W-1:0]       hash_mem  [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0]   key_mem   [MAX_ENTRIES];
	logic [VALUE_WIDTH-1:0] val_mem   [MAX_ENTRIES];
	logic [LINK_W-1:0]      next_mem  [MAX_ENTRIES];

	logic [LINK_W-1:0]      head_rd;
	logic [H31_W-1:0]       hash_rd;
	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic [LINK_W-1:0]      next_rd;

	// request and walk registers
	logic [LINK_W-1:0]      cap_q;
	logic [H31_W-1:0]       h31_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	req_t                   req_q;
	logic [LINK_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [LINK_W-1:0]      head_q;
	logic [LINK_W-1:0]      cur_q;
	logic [LINK_W-1:0]      prev_q;
	logic [LINK_W-1:0]      steps_q;
	logic [IDX_W-1:0]       hit_q;
	logic [LINK_W-1:0]      hnext_q;
	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       clr_q;
	logic [LINK_W-1:0]      used_q;
	logic [LINK_W-1:0]      free_head_q;
	logic [LINK_W-1:0]      free_cnt_q;
	logic [VER_W-1:0]       ver_q;

	// result registers
	stat_code_t             res_stat_q;
	logic                   res_found_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [IDX_W-1:0]       res_idx_q;

	logic [LINK_W-1:0]      cap_new;
	logic [LINK_W:0]        trial;
	logic [DIV_CNT_W-1:0]   bit_sel;
	logic [IDX_W-1:0]       bucket;

	assign bucket  = rem_q[IDX_W-1:0];
	assign bit_sel = DIV_LAST - div_cnt_q;
	assign trial   = {rem_q, h31_q[bit_sel]};

	always_comb begin
		if (cfg_data == '0) cap_new = LINK_W'(1);
		else if (32'(cfg_data) > 32'(MAX_ENTRIES)) cap_new = NIL;
		else cap_new = LINK_W'(cfg_data);
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (cmd == CMD_CLEAR) head_mem[clr_q] <= NIL;
		else if (cmd == CMD_UNLINK && prev_q == NIL) head_mem[bucket] <= hnext_q;
		else if (cmd == CMD_WRITE) head_mem[bucket] <= LINK_W'(slot_q);
		if (cmd == CMD_HEAD_RD) head_rd <= head_mem[bucket];
	end

	// entry fields
	always_ff @(posedge clk) begin
		if (cmd == CMD_WRITE) begin
			hash_mem[slot_q] <= h31_q;
			key_mem[slot_q]  <= key_q;
		end
		if (cmd == CMD_ENT_RD) begin
			hash_rd <= hash_mem[cur_q[IDX_W-1:0]];
			key_rd  <= key_mem[cur_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_WRITE) val_mem[slot_q] <= val_q;
		else if (cmd == CMD_REPLACE) val_mem[hit_q] <= val_q;
		if (cmd == CMD_ENT_RD) val_rd <= val_mem[cur_q[IDX_W-1:0]];
	end

	// chain links, one write port
	always_ff @(posedge clk) begin
		if (cmd == CMD_WRITE) next_mem[slot_q] <= head_q;
		else if (cmd == CMD_UNLINK && prev_q != NIL) next_mem[prev_q[IDX_W-1:0]] <= hnext_q;
		else if (cmd == CMD_PUSH)
			next_mem[hit_q] <= (free_cnt_q != '0) ? free_head_q : NIL;
		if (cmd == CMD_ENT_RD) next_rd <= next_mem[cur_q[IDX_W-1:0]];
		else if (cmd == CMD_ALLOC_RD) next_rd <= next_mem[free_head_q[IDX_W-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RST;
			clr_q       <= '0;
			used_q      <= '0;
			free_head_q <= NIL;
			free_cnt_q  <= '0;
			ver_q       <= '0;
			div_cnt_q   <= '0;
		end else if (cfg_fire) begin
			cap_q       <= cap_new;
			clr_q       <= '0;
			used_q      <= '0;
			free_head_q <= NIL;
			free_cnt_q  <= '0;
		end else begin
			case (cmd)
				CMD_CLEAR:  clr_q <= clr_q + 1'b1;
				CMD_LOAD:   div_cnt_q <= '0;
				CMD_DIV:    div_cnt_q <= div_cnt_q + 1'b1;
				CMD_REPLACE: ver_q <= ver_q + 1'b1;
				CMD_PUSH: begin
					free_head_q <= LINK_W'(hit_q);
					free_cnt_q  <= free_cnt_q + 1'b1;
					ver_q       <= ver_q + 1'b1;
				end
				CMD_ALLOC_POP: begin
					free_head_q <= next_rd;
					free_cnt_q  <= free_cnt_q - 1'b1;
				end
				CMD_TAKE_NEW: used_q <= used_q + 1'b1;
				CMD_WRITE:  ver_q <= ver_q + 1'b1;
				default: ;
			endcase
		end
	end

	// request payload and walk
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				h31_q <= hash_in[30:0] ^ hash_in[62:32];
				key_q <= key;
				val_q <= value_in;
				req_q <= req_t'(req_type);
				rem_q <= '0;
			end
			CMD_DIV: rem_q <= (trial >= {1'b0, cap_q}) ? LINK_W'(trial - {1'b0, cap_q})
				: LINK_W'(trial);
			CMD_HEAD_TAKE: begin
				head_q  <= head_rd;
				cur_q   <= head_rd;
				prev_q  <= NIL;
				steps_q <= '0;
			end
			CMD_ADV: begin
				prev_q  <= cur_q;
				cur_q   <= next_rd;
				steps_q <= steps_q + 1'b1;
			end
			CMD_HIT: begin
				hit_q   <= cur_q[IDX_W-1:0];
				hnext_q <= next_rd;
			end
			CMD_ALLOC_POP: slot_q <= free_head_q[IDX_W-1:0];
			CMD_TAKE_NEW:  slot_q <= used_q[IDX_W-1:0];
			default: ;
		endcase
	end

	// result fields
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_FIN_LOOKUP: begin
				res_stat_q <= ST_OK; res_found_q <= 1'b1; res_val_q <= val_rd; res_idx_q <= hit_q;
			end
			CMD_PUSH: begin
				res_stat_q <= ST_OK; res_found_q <= 1'b1; res_val_q <= '0; res_idx_q <= hit_q;
			end
			CMD_REPLACE: begin
				res_stat_q <= ST_OK; res_found_q <= 1'b0; res_val_q <= '0; res_idx_q <= hit_q;
			end
			CMD_FIN_DUP: begin
				res_stat_q <= ST_DUPLICATE; res_found_q <= 1'b0; res_val_q <= '0;
				res_idx_q <= hit_q;
			end
			CMD_WRITE: begin
				res_stat_q <= ST_OK; res_found_q <= 1'b0; res_val_q <= '0; res_idx_q <= slot_q;
			end
			CMD_FIN_MISS: begin
				res_stat_q <= ST_NOT_FOUND; res_found_q <= 1'b0; res_val_q <= '0;
				res_idx_q <= '0;
			end
			CMD_FIN_FULL: begin
				res_stat_q <= ST_FULL; res_found_q <= 1'b0; res_val_q <= '0; res_idx_q <= '0;
			end
			default: ;
		endcase
	end

	assign stat.clear_last = (clr_q == CLR_LAST);
	assign stat.div_last   = (div_cnt_q == DIV_LAST);
	assign stat.walk_ok    = (cur_q < cap_q) && (steps_q < cap_q);
	assign stat.match      = (hash_rd == h31_q) && (key_rd == key_q);
	assign stat.free_avail = (free_cnt_q != '0) && (free_head_q < cap_q);
	assign stat.used_avail = (used_q < cap_q);
	assign stat.req        = req_q;

	assign status      = res_stat_q;
	assign found       = res_found_q;
	assign value_out   = res_val_q;
	assign entry_index = IDX_OUT_W'(res_idx_q);
	assign live_count  = LIVE_W'(used_q - free_cnt_q);
	assign version     = ver_q;

	`CHM_ASSERT_IMP(a_used_cap, clk, arst_n, 1'b1, used_q <= cap_q, "slot count above capacity")
	`CHM_ASSERT_IMP(a_free_used, clk, arst_n, 1'b1, free_cnt_q <= used_q,
		"free list longer than used slots")
	`CHM_ASSERT_IMP(a_bucket_range, clk, arst_n, cmd == CMD_HEAD_RD, rem_q < cap_q,
		"bucket index not reduced below capacity")

endmodule

/* tb/sv/tb_chained_hash_map_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_chained_hash_map_engine_top
// self-checking bench for the chained hash map engine: a short table of
// directed requests, then random traffic over several capacities; results
// compared field by field against typed rows or an in-bench model of the map
// ----------------------------------------------------------------------------
module tb_chained_hash_map_engine_top;
	import chmap_pkg::*;

	localparam int CAP_MAX  = MAX_ENTRIES_DEF;
	localparam int NIL      = CAP_MAX;      // end-of-chain / empty link
	localparam int DRAIN    = 64;           // settle cycles, above one request
	localparam int POOL     = 12;           // keys per phase, so hits are common
	localparam int NUM_DIR  = 15;

	// result of one request
	typedef struct packed {
		stat_code_t  st;
		logic        hit;
		logic [31:0] val;
		logic [9:0]  idx;
		logic [10:0] live;
		logic [31:0] ver;
	} map_result_t;

	// directed row; typed result used only when use_typed is set
	typedef struct packed {
		req_t        rq;
		logic [63:0] hash;
		logic [31:0] k;
		logic [31:0] v;
		logic        use_typed;
		map_result_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [63:0] hash_in = '0;
	logic [31:0] key = '0;
	logic [31:0] value_in = '0;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [31:0] value_out;
	logic [9:0]  entry_index;
	logic [10:0] live_count;
	logic [31:0] version;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	chained_hash_map_engine_top u_top (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .hash_in(hash_in), .key(key), .value_in(value_in),
		.done(done), .status(status), .found(found), .value_out(value_out),
		.entry_index(entry_index), .live_count(live_count), .version(version),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---- shadow copy of the map ----
	int unsigned map_cap;
	int unsigned map_head [CAP_MAX];
	logic [30:0] map_hash [CAP_MAX];
	logic [31:0] map_key  [CAP_MAX];
	logic [31:0] map_val  [CAP_MAX];
	int unsigned map_next [CAP_MAX];
	int unsigned map_used, map_free_head, map_free_cnt;
	logic [31:0] map_ver;

	map_result_t pending_results[$];
	int          err_cnt = 0;
	int          checked_cnt = 0;
	int          sent_cnt = 0;
	int          cap_writes = 0;
	int          sender_idle_pct = 30;

	// register write clears the table, version is kept
	function automatic void map_clear(int unsigned cap_wr);
		map_cap = (cap_wr == 0) ? 1 : (cap_wr > CAP_MAX) ? CAP_MAX : cap_wr;
		foreach (map_head[i]) begin
			map_head[i] = NIL;
			map_next[i] = NIL;
		end
		map_used = 0;
		map_free_head = NIL;
		map_free_cnt = 0;
	endfunction

	// apply one request to the shadow map and return what the block must report
	function automatic map_result_t map_apply(req_t rq, logic [63:0] h, logic [31:0] k,
			logic [31:0] v);
		map_result_t r;
		logic [30:0] h31;
		int unsigned bkt, cur, prev, hit, steps, slot;
		// fold the halves, top bit of each half dropped
		h31 = h[30:0] ^ h[62:32];
		bkt = h31 % map_cap;
		cur = map_head[bkt];
		prev = NIL;
		hit = NIL;
		steps = 0;
		while (cur < map_cap && steps < map_cap && hit == NIL) begin
			if (map_hash[cur] == h31 && map_key[cur] == k)
				hit = cur;
			else begin
				prev = cur;
				cur = map_next[cur];
				steps++;
			end
		end
		r = '0;
		r.st = ST_OK;
		case (rq)
			REQ_LOOKUP: begin
				if (hit != NIL) begin
					r.hit = 1'b1;
					r.val = map_val[hit];
					r.idx = hit[9:0];
				end else
					r.st = ST_NOT_FOUND;
			end
			REQ_REMOVE: begin
				if (hit != NIL) begin
					if (prev == NIL)
						map_head[bkt] = map_next[hit];
					else
						map_next[prev] = map_next[hit];
					map_next[hit] = (map_free_cnt > 0) ? map_free_head : NIL;
					map_free_head = hit;
					map_free_cnt++;
					map_ver++;
					r.hit = 1'b1;
					r.idx = hit[9:0];
				end else
					r.st = ST_NOT_FOUND;
			end
			default: begin
				if (hit != NIL) begin
					r.idx = hit[9:0];
					if (rq == REQ_ADD)
						r.st = ST_DUPLICATE;
					else begin
						map_val[hit] = v;
						map_ver++;
					end
				end else begin
					slot = NIL;
					if (map_free_cnt > 0 && map_free_head < map_cap) begin
						slot = map_free_head;
						map_free_head = map_next[slot];
						map_free_cnt--;
					end else if (map_used < map_cap) begin
						slot = map_used;
						map_used++;
					end
					if (slot == NIL)
						r.st = ST_FULL;
					else begin
						map_hash[slot] = h31;
						map_key[slot] = k;
						map_val[slot] = v;
						map_next[slot] = map_head[bkt];
						map_head[bkt] = slot;
						map_ver++;
						r.idx = slot[9:0];
					end
				end
			end
		endcase
		r.live = 11'(map_used - map_free_cnt);
		r.ver = map_ver;
		return r;
	endfunction

	// drive one request; start is left high so back-to-back requests need no drop
	task automatic send_request(req_t rq, logic [63:0] h, logic [31:0] k, logic [31:0] v,
			logic use_typed, map_result_t typed);
		map_result_t r;
		int gap;
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		hash_in <= h;
		key <= k;
		value_in <= v;
		// transfer happens on the first edge that sees busy low
		do @(posedge clk); while (busy);
		r = map_apply(rq, h, k, v);
		pending_results.push_back(use_typed ? typed : r);
		sent_cnt++;
	endtask

	// capacity write only with nothing in flight
	task automatic write_capacity(logic [10:0] cap_wr);
		start <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap_wr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		map_clear(cap_wr);
		cap_writes++;
	endtask

	// ---- result checker ----
	always @(posedge clk) begin
		map_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				err_cnt++;
			end else begin
				e = pending_results.pop_front();
				checked_cnt++;
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					err_cnt++;
				end
				if (found !== e.hit) begin
					$error("found exp %0d got %0d", e.hit, found);
					err_cnt++;
				end
				if (value_out !== e.val) begin
					$error("value_out exp %h got %h", e.val, value_out);
					err_cnt++;
				end
				if (entry_index !== e.idx) begin
					$error("entry_index exp %0d got %0d", e.idx, entry_index);
					err_cnt++;
				end
				if (live_count !== e.live) begin
					$error("live_count exp %0d got %0d", e.live, live_count);
					err_cnt++;
				end
				if (version !== e.ver) begin
					$error("version exp %0d got %0d", e.ver, version);
					err_cnt++;
				end
			end
		end
	end

	// ---- watchdog ----
	initial begin
		#(8 * 2000000);
		$display("TEST FAILED");
		$finish;
	end

	// ---- stimulus ----
	initial begin
		dir_row_t    dir_rows [NUM_DIR];
		logic [31:0] pool_key  [POOL];
		logic [63:0] pool_hash [POOL];
		logic [10:0] phase_cap [6];
		int          phase_len [6];
		int          total_rand, rand_idx, p;
		req_t        rq;
		logic [63:0] h;
		logic [31:0] k;

		// reset values: capacity 1021, empty table, version zero
		map_ver = '0;
		map_clear(RESET_CAPACITY);

		// directed: extremes of fields, every request type, replace, duplicate,
		// bucket sharing by hash fold, free-list reuse; later rows go to the model
		dir_rows[0]  = '{REQ_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b1,
			'{ST_NOT_FOUND, 1'b0, 32'h0, 10'd0, 11'd0, 32'd0}};
		dir_rows[1]  = '{REQ_REMOVE, '1, '1, '1, 1'b1,
			'{ST_NOT_FOUND, 1'b0, 32'h0, 10'd0, 11'd0, 32'd0}};
		dir_rows[2]  = '{REQ_INSERT, '1, '1, '1, 1'b1,
			'{ST_OK, 1'b0, 32'h0, 10'd0, 11'd1, 32'd1}};
		dir_rows[3]  = '{REQ_LOOKUP, '1, '1, 32'h0, 1'b1,
			'{ST_OK, 1'b1, 32'hFFFF_FFFF, 10'd0, 11'd1, 32'd1}};
		dir_rows[4]  = '{REQ_ADD, '1, '1, 32'h0, 1'b1,
			'{ST_DUPLICATE, 1'b0, 32'h0, 10'd0, 11'd1, 32'd1}};
		dir_rows[5]  = '{REQ_INSERT, '1, '1, 32'h0, 1'b1,
			'{ST_OK, 1'b0, 32'h0, 10'd0, 11'd1, 32'd2}};
		dir_rows[6]  = '{REQ_INSERT, 64'h0, 32'h0, 32'h0, 1'b1,
			'{ST_OK, 1'b0, 32'h0, 10'd1, 11'd2, 32'd3}};
		dir_rows[7]  = '{REQ_ADD, 64'h8000_0000_0000_0000, 32'h1, 32'h1234_5678, 1'b1,
			'{ST_OK, 1'b0, 32'h0, 10'd2, 11'd3, 32'd4}};
		dir_rows[8]  = '{REQ_REMOVE, '1, '1, 32'h0, 1'b1,
			'{ST_OK, 1'b1, 32'h0, 10'd0, 11'd2, 32'd5}};
		dir_rows[9]  = '{REQ_INSERT, 64'h5, 32'h2, 32'h5A5A_5A5A, 1'b0, '0};
		dir_rows[10] = '{REQ_REMOVE, 64'h0, 32'h0, 32'h0, 1'b0, '0};
		dir_rows[11] = '{REQ_REMOVE, 64'h8000_0000_0000_0000, 32'h1, 32'h0, 1'b0, '0};
		dir_rows[12] = '{REQ_INSERT, 64'h7FFF_FFFF_0000_0000, 32'h3, 32'hA5A5_A5A5,
			1'b0, '0};
		dir_rows[13] = '{REQ_LOOKUP, 64'h7FFF_FFFF_0000_0000, 32'h3, 32'h0, 1'b0, '0};
		dir_rows[14] = '{REQ_REMOVE, 64'h5, 32'h2, 32'h0, 1'b0, '0};

		// capacity 1021 from reset, zero (treated as one), small primes,
		// above the maximum (saturates), two
		phase_cap = '{11'd1021, 11'd0, 11'd7, 11'd2047, 11'd13, 11'd2};
		phase_len = '{100, 60, 120, 100, 120, 50};
		total_rand = 550;
		rand_idx = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// reset clearing pass must finish before the first transfer
		do @(posedge clk); while (busy);

		foreach (dir_rows[i])
			send_request(dir_rows[i].rq, dir_rows[i].hash, dir_rows[i].k, dir_rows[i].v,
				dir_rows[i].use_typed, dir_rows[i].res);

		for (p = 0; p < 6; p++) begin
			if (p > 0)
				write_capacity(phase_cap[p]);
			// fresh key pool; some keys share a hash to build longer chains
			for (int i = 0; i < POOL; i++) begin
				pool_key[i] = $urandom;
				pool_hash[i] = (i > 0 && $urandom_range(3) == 0) ? pool_hash[i-1]
					: {$urandom, $urandom};
			end
			for (int n = 0; n < phase_len[p]; n++) begin
				// sender pauses before 30% of requests, then 59%, then never
				sender_idle_pct = (rand_idx < total_rand / 3) ? 30
					: (rand_idx < 2 * total_rand / 3) ? 59 : 0;
				case ($urandom_range(99)) inside
					[0:24]:  rq = REQ_LOOKUP;
					[25:54]: rq = REQ_INSERT;
					[55:74]: rq = REQ_ADD;
					default: rq = REQ_REMOVE;
				endcase
				if ($urandom_range(9) == 0) begin
					h = {$urandom, $urandom};
					k = $urandom;
				end else begin
					h = pool_hash[$urandom_range(POOL - 1)];
					k = pool_key[$urandom_range(POOL - 1)];
					// mostly keep the key on its own hash so lookups hit
					if ($urandom_range(3) != 0) begin
						int j;
						j = $urandom_range(POOL - 1);
						h = pool_hash[j];
						k = pool_key[j];
					end
				end
				send_request(rq, h, k, $urandom, 1'b0, '0);
				rand_idx++;
			end
		end
		start <= 1'b0;

		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests sent over %0d capacity writes, %0d results checked",
			sent_cnt, cap_writes, checked_cnt);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/chmap_pkg.sv
hw/rtl/chmap_ctrl.sv
hw/rtl/chmap_dp.sv
hw/rtl/chained_hash_map_engine_top.sv
tb/sv/tb_chained_hash_map_engine_top.sv
